@@ rtl/core/sliding_window_anagram_search_top_assert.svh @@
// Assertion macros for the anagram search core.
`ifndef SLIDING_WINDOW_ANAGRAM_SEARCH_TOP_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/swas_pkg.sv @@
`timescale 1ns / 1ps

package swas_pkg;

  // Sizing of the search core.
  localparam int MaxPattern  = 64;
  localparam int PosBits     = 16;
  localparam int SymW        = 8;
  localparam int MatchStartW = 16;
  localparam int TblDepth    = 1 << SymW;
  localparam int CntW        = $clog2(MaxPattern + 1);
  localparam int BalW        = CntW + 1;
  localparam int RingAw      = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  // Request type codes.
  localparam logic ReqPattern = 1'b0;
  localparam logic ReqText    = 1'b1;

  // One input item.
  typedef struct packed {
    logic            req_type;
    logic [SymW-1:0] symbol;
    logic            first;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                   match;
    logic [MatchStartW-1:0] match_start;
    logic                   overflow;
  } out_item_t;

  // One entry of the symbol count table.
  typedef struct packed {
    logic            in_pat;
    logic [BalW-1:0] bal;
  } tbl_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ENTER,
    ST_WR_ENTER,
    ST_RD_RING,
    ST_RD_LEAVE,
    ST_WR_LEAVE,
    ST_FINISH,
    ST_OUT
  } state_e;

endpackage

@@ rtl/core/sliding_window_anagram_search_top.sv @@
// One item at a time: in_stall_o holds off new items while the sequencer is busy.
// A pattern item passes table read, table write and output; a text item passes table read
// and write for the entering symbol, ring read and table read and write for the leaving one
// once the window is full, then finish and output. A stalled output holds the output state.
// The count table has a single port and takes each read and write in its own state.
// Reset clears all control state and the table valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module sliding_window_anagram_search_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  swas_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output swas_pkg::out_item_t out_item_o
);

  `include "sliding_window_anagram_search_top_assert.svh"

  swas_pkg::state_e state_q, state_d;

  swas_pkg::in_item_t  item_q;
  swas_pkg::out_item_t res_q, res_d;
  swas_pkg::out_item_t out_item_q;
  logic                out_valid_q, out_valid_d;

  logic [swas_pkg::CntW-1:0]    plen_q, plen_d;
  logic [swas_pkg::CntW-1:0]    distinct_q, distinct_d;
  logic [swas_pkg::CntW-1:0]    zero_q, zero_d;
  logic [swas_pkg::CntW-1:0]    fill_q, fill_d;
  logic [swas_pkg::PosBits-1:0] pos_q, pos_d;
  logic [swas_pkg::RingAw-1:0]  head_q, head_d;

  // Count table and its valid bits.
  swas_pkg::tbl_entry_t             tbl_mem [swas_pkg::TblDepth];
  swas_pkg::tbl_entry_t             tbl_rdata_q;
  logic                             rd_vld_q;
  logic [swas_pkg::TblDepth-1:0]    tbl_vld_q;
  logic [swas_pkg::SymW-1:0]        tbl_addr;
  logic                             tbl_re, tbl_we, tbl_clr;
  swas_pkg::tbl_entry_t             tbl_wdata;

  // Window ring.
  logic [swas_pkg::SymW-1:0]   ring_mem [swas_pkg::MaxPattern];
  logic [swas_pkg::SymW-1:0]   ring_rdata_q;
  logic [swas_pkg::RingAw-1:0] ring_idx;
  logic                        ring_re, ring_we;

  logic                      in_acc, out_load;
  logic                      load_ok, leave_needed, bal_inc;
  logic [swas_pkg::BalW-1:0] bal_old, bal_new;
  logic                      inpat_old;
  logic [swas_pkg::CntW-1:0] head_ext, fill_next;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == swas_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // Status derived from the stored counters.
  assign load_ok      = (pos_q == '0) && (fill_q == '0);
  assign leave_needed = (plen_q != '0) && (fill_q >= plen_q);
  assign head_ext     = swas_pkg::CntW'(head_q);
  assign fill_next    = (fill_q < swas_pkg::CntW'(swas_pkg::MaxPattern)) ?
                        fill_q + 1'b1 : fill_q;

  // Ring slot of the symbol that leaves the window.
  always_comb begin
    if (head_ext >= plen_q) begin
      ring_idx = swas_pkg::RingAw'(head_ext - plen_q);
    end else begin
      ring_idx = swas_pkg::RingAw'(head_ext + swas_pkg::CntW'(swas_pkg::MaxPattern) - plen_q);
    end
  end

  // Shared read-modify-write unit: an entry not yet written reads as zero.
  assign bal_old   = rd_vld_q ? tbl_rdata_q.bal : '0;
  assign inpat_old = rd_vld_q && tbl_rdata_q.in_pat;
  assign bal_inc   = (state_q == swas_pkg::ST_WR_LEAVE) ||
                     (item_q.req_type == swas_pkg::ReqPattern);
  assign bal_new   = bal_inc ? bal_old + 1'b1 : bal_old - 1'b1;

  // The table address follows the entering symbol, then the leaving one.
  assign tbl_addr = ((state_q == swas_pkg::ST_RD_LEAVE) || (state_q == swas_pkg::ST_WR_LEAVE)) ?
                    ring_rdata_q : item_q.symbol;
  assign tbl_re   = (state_q == swas_pkg::ST_RD_ENTER) || (state_q == swas_pkg::ST_RD_LEAVE);
  assign ring_re  = (state_q == swas_pkg::ST_RD_RING);
  assign in_stall_o = (state_q != swas_pkg::ST_IDLE);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swas_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = swas_pkg::ST_RD_ENTER;
        end
      end
      swas_pkg::ST_RD_ENTER: state_d = swas_pkg::ST_WR_ENTER;
      swas_pkg::ST_WR_ENTER: begin
        if (item_q.req_type == swas_pkg::ReqPattern) begin
          state_d = swas_pkg::ST_OUT;
        end else if (leave_needed) begin
          state_d = swas_pkg::ST_RD_RING;
        end else begin
          state_d = swas_pkg::ST_FINISH;
        end
      end
      swas_pkg::ST_RD_RING:  state_d = swas_pkg::ST_RD_LEAVE;
      swas_pkg::ST_RD_LEAVE: state_d = swas_pkg::ST_WR_LEAVE;
      swas_pkg::ST_WR_LEAVE: state_d = swas_pkg::ST_FINISH;
      swas_pkg::ST_FINISH:   state_d = swas_pkg::ST_OUT;
      swas_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = swas_pkg::ST_IDLE;
        end
      end
      default: state_d = swas_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and counter updates for each state.
  always_comb begin
    plen_d     = plen_q;
    distinct_d = distinct_q;
    zero_d     = zero_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    head_d     = head_q;
    res_d      = res_q;
    tbl_we     = 1'b0;
    tbl_clr    = 1'b0;
    ring_we    = 1'b0;
    tbl_wdata  = '{in_pat: 1'b1, bal: bal_new};
    unique case (state_q)
      swas_pkg::ST_IDLE: begin
        // A first pattern byte restarts the whole search.
        if (in_acc && (in_item_i.req_type == swas_pkg::ReqPattern) && in_item_i.first) begin
          plen_d     = '0;
          distinct_d = '0;
          zero_d     = '0;
          fill_d     = '0;
          pos_d      = '0;
          head_d     = '0;
          tbl_clr    = 1'b1;
        end
      end
      swas_pkg::ST_WR_ENTER: begin
        if (item_q.req_type == swas_pkg::ReqPattern) begin
          res_d = '0;
          if (load_ok) begin
            if (plen_q >= swas_pkg::CntW'(swas_pkg::MaxPattern)) begin
              res_d.overflow = 1'b1;
            end else begin
              plen_d = plen_q + 1'b1;
              tbl_we = 1'b1;
              if (!inpat_old) begin
                distinct_d = distinct_q + 1'b1;
              end
            end
          end
        end else if ((plen_q != '0) && inpat_old) begin
          tbl_we = 1'b1;
          if (bal_new == '0) begin
            zero_d = zero_q + 1'b1;
          end else if (bal_old == '0) begin
            zero_d = zero_q - 1'b1;
          end
        end
      end
      swas_pkg::ST_WR_LEAVE: begin
        if (inpat_old) begin
          tbl_we = 1'b1;
          if (bal_new == '0) begin
            zero_d = zero_q + 1'b1;
          end else if (bal_old == '0) begin
            zero_d = zero_q - 1'b1;
          end
        end
      end
      swas_pkg::ST_FINISH: begin
        // Store the text byte, advance the window and judge the match.
        ring_we = 1'b1;
        head_d  = (head_q == swas_pkg::RingAw'(swas_pkg::MaxPattern - 1)) ?
                  '0 : head_q + 1'b1;
        fill_d  = fill_next;
        res_d   = '0;
        if ((plen_q != '0) && (fill_next >= plen_q) && (zero_q == distinct_q)) begin
          res_d.match       = 1'b1;
          res_d.match_start = swas_pkg::MatchStartW'(pos_q) + 1'b1 -
                              swas_pkg::MatchStartW'(plen_q);
        end
        if (pos_q != '1) begin
          pos_d = pos_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: holds a result until the receiver takes it.
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      plen_q      <= '0;
      distinct_q  <= '0;
      zero_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      head_q      <= '0;
      tbl_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      plen_q      <= plen_d;
      distinct_q  <= distinct_d;
      zero_q      <= zero_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      head_q      <= head_d;
      if (tbl_clr) begin
        tbl_vld_q <= '0;
      end else if (tbl_we) begin
        tbl_vld_q[tbl_addr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  // Count table: one port, read data registered.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_addr];
      rd_vld_q    <= tbl_vld_q[tbl_addr];
    end
  end

  // Window ring: written at the head, read at the leaving slot.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= item_q.symbol;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks on the counters and the sequencer.
  `SWAS_ASSERT_NOW(a_zero_le_distinct, clk_i, rst_ni, 1'b1, zero_q <= distinct_q,
                   "more zero-balance symbols than distinct pattern symbols")
  `SWAS_ASSERT_NOW(a_plen_bound, clk_i, rst_ni, 1'b1,
                   plen_q <= swas_pkg::CntW'(swas_pkg::MaxPattern),
                   "pattern length beyond its maximum")
  `SWAS_ASSERT_NOW(a_match_no_ovf, clk_i, rst_ni, out_valid_o,
                   !(out_item_o.match && out_item_o.overflow),
                   "a result carries both a match and an overflow")
  `SWAS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q == swas_pkg::ST_RD_ENTER,
                    "an accepted item did not start the table read")

endmodule
